@@ hw/rtl/cgrb_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock generator register block package
// Shared widths, word offsets and reset values.
// ----------------------------------------------------------------------------
package cgrb_pkg;

  localparam int unsigned RegWords = 1024;
  localparam int unsigned AddrW    = $clog2(RegWords);

  localparam logic [11:0] WVersion = 12'h000;
  localparam logic [11:0] WParam   = 12'h001;
  localparam logic [11:0] WStatus  = 12'h004;
  localparam logic [11:0] WRunCtl  = 12'h005;
  localparam logic [11:0] WSosc    = 12'h040;
  localparam logic [11:0] WSirc    = 12'h080;
  localparam logic [11:0] WFirc    = 12'h0C0;
  localparam logic [11:0] WFircCfg = 12'h0C2;
  localparam logic [11:0] WRosc    = 12'h100;
  localparam logic [11:0] WPllA    = 12'h140;
  localparam logic [11:0] WPllS    = 12'h180;
  localparam logic [11:0] WLdo     = 12'h200;

  localparam logic [3:0] PCsr   = 4'd0;
  localparam logic [3:0] PCtrl  = 4'd1;
  localparam logic [3:0] PNdiv  = 4'd3;
  localparam logic [3:0] PMdiv  = 4'd4;
  localparam logic [3:0] PPdiv  = 4'd5;
  localparam logic [3:0] PLock  = 4'd6;
  localparam logic [3:0] PSscg1 = 4'd10;

  localparam logic [31:0] ReadyBit   = 32'h0100_0000;
  localparam logic [31:0] VersionVal = 32'h0601_0000;

  localparam logic [31:0] HzSosc  = 32'd16000000;
  localparam logic [31:0] HzFro48 = 32'd48000000;
  localparam logic [31:0] HzFro144 = 32'd144000000;
  localparam logic [31:0] HzRosc  = 32'd32768;
  localparam logic [31:0] HzFro12 = 32'd12000000;

  // Reset value of one word of the window.
  function automatic logic [31:0] reset_word(input logic [11:0] a);
    logic [31:0] v;
    v = 32'd0;
    if (a == WRunCtl) v = 32'h0300_0000;
    if (a == WSirc) v = 32'h0100_0020;
    if (a == WFirc) v = 32'h0100_0001;
    if (a == WLdo) v = 32'd8;
    if (a == WPllA + 12'(PNdiv) || a == WPllA + 12'(PMdiv) || a == WPllA + 12'(PPdiv) ||
        a == WPllS + 12'(PNdiv) || a == WPllS + 12'(PMdiv) || a == WPllS + 12'(PPdiv))
      v = 32'd1;
    if (a == WPllA + 12'(PLock) || a == WPllS + 12'(PLock)) v = 32'h0000_4F4C;
    if (a == WPllA + 12'(PSscg1) || a == WPllS + 12'(PSscg1)) v = 32'h8000_0000;
    return v;
  endfunction

  // Operands handed to the serial divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

@@ hw/rtl/clock_generator_register_block.sv @@
// ----------------------------------------------------------------------------
// Clock generator register block
// Register window with derived clock frequency report.
// ----------------------------------------------------------------------------
// Each request is one read or write of a 32-bit word. One response follows
// each request with the read data and five frequencies in Hz, and the next
// request is taken only after that response has been accepted. After the
// request is accepted, the block performs the access in one state and latches
// the read word in the state after it. It then sweeps the sixteen control
// words through the registered read port of the word memory. Each running PLL
// then passes through a setup state, a serial divide by N, a serial multiply
// by M and a serial divide by the post divider, all on one shared divider and
// multiplier. A PLL that is off or has no input clock passes only through its
// setup state. The response is then offered from the output state, and the
// block waits there while the receiver holds off the response. After reset a
// clearing pass writes the reset values to all 1024 words, one per cycle,
// before the first request is taken.
module clock_generator_register_block (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // write_data[31:0], word_index[43:32], pad
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [183:0] m_axis_tdata  // read_data, slow_fro_hz, frohf_hz, pll_a_hz,
                                     // pll_s_hz, main_hz, pad
);

  localparam int unsigned AW = cgrb_pkg::AddrW;

  typedef enum logic [3:0] {
    StClear, StIdle, StAccess, StRdWait, StFetch, StPll, StDiv1, StMul, StDiv2,
    StOut
  } state_e;

  state_e state_q;

  // Word memory, read data registered.
  logic [31:0] mem [cgrb_pkg::RegWords];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [AW:0]   clr_q;
  logic          kind_q;
  logic [11:0]   idx_q;
  logic [31:0]   wd_q;
  logic [3:0]    fetch_q;   // fetch slot, one behind the address
  logic          fvalid_q;
  logic [31:0]   rd_q;
  logic [31:0]   runctl_q, sosc_q, sirc_q, firc_q, fcfg_q, rosc_q;
  logic [31:0]   csr_q [2];
  logic [31:0]   ctl_q [2];
  logic [7:0]    ndiv_q [2];
  logic [15:0]   mdiv_q [2];
  logic [4:0]    pdiv_q [2];
  logic          pll_q;
  logic [31:0]   hz_q [2];
  logic [5:0]    pd_q;

  // Sweep order of the words needed for the frequency report.
  function automatic logic [11:0] fetch_addr(input logic [3:0] s);
    logic [11:0] a;
    a = cgrb_pkg::WRunCtl;
    case (s)
      4'd0:  a = cgrb_pkg::WRunCtl;
      4'd1:  a = cgrb_pkg::WSosc;
      4'd2:  a = cgrb_pkg::WSirc;
      4'd3:  a = cgrb_pkg::WFirc;
      4'd4:  a = cgrb_pkg::WFircCfg;
      4'd5:  a = cgrb_pkg::WRosc;
      4'd6:  a = cgrb_pkg::WPllA + 12'(cgrb_pkg::PCsr);
      4'd7:  a = cgrb_pkg::WPllA + 12'(cgrb_pkg::PCtrl);
      4'd8:  a = cgrb_pkg::WPllA + 12'(cgrb_pkg::PNdiv);
      4'd9:  a = cgrb_pkg::WPllA + 12'(cgrb_pkg::PMdiv);
      4'd10: a = cgrb_pkg::WPllA + 12'(cgrb_pkg::PPdiv);
      4'd11: a = cgrb_pkg::WPllS + 12'(cgrb_pkg::PCsr);
      4'd12: a = cgrb_pkg::WPllS + 12'(cgrb_pkg::PCtrl);
      4'd13: a = cgrb_pkg::WPllS + 12'(cgrb_pkg::PNdiv);
      4'd14: a = cgrb_pkg::WPllS + 12'(cgrb_pkg::PMdiv);
      default: a = cgrb_pkg::WPllS + 12'(cgrb_pkg::PPdiv);
    endcase
    return a;
  endfunction

  logic in_win, wr_ok;
  assign in_win = idx_q < 12'(cgrb_pkg::RegWords);
  assign wr_ok  = kind_q && in_win && idx_q != cgrb_pkg::WVersion &&
                  idx_q != cgrb_pkg::WParam && idx_q != cgrb_pkg::WStatus;

  logic [3:0] slot_q;
  logic [11:0] faddr;
  assign faddr = fetch_addr(slot_q);

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = wd_q;
    raddr = idx_q[AW-1:0];
    if (state_q == StClear) begin
      we    = 1'b1;
      waddr = clr_q[AW-1:0];
      wdata = cgrb_pkg::reset_word(12'(clr_q[AW-1:0]));
    end else if (state_q == StAccess) begin
      we = wr_ok;
    end else if (state_q == StFetch) begin
      raddr = faddr[AW-1:0];
    end
  end

  // PLL operand setup for the selected PLL.
  logic [31:0] csr_s, ctl_s, fin_s, n_s;
  logic [5:0]  pd_s;
  always_comb begin
    csr_s = csr_q[pll_q];
    ctl_s = ctl_q[pll_q];
    case (ctl_s[26:25])
      2'd0: fin_s = sosc_q[0] ? cgrb_pkg::HzSosc : 32'd0;
      2'd1: fin_s = firc_q[0] ? cgrb_pkg::HzFro48 : 32'd0;
      2'd2: fin_s = rosc_q[16] ? cgrb_pkg::HzRosc : 32'd0;
      default: fin_s = 32'd0;
    endcase
    if (csr_s[1:0] == 2'b00) fin_s = 32'd0;
    n_s = ctl_s[19] ? 32'd1 : {24'd0, ndiv_q[pll_q]};
    if (n_s == 32'd0) n_s = 32'd1;
    if (ctl_s[20]) pd_s = 6'd1;
    else if (ctl_s[16]) pd_s = {1'b0, pdiv_q[pll_q]};
    else pd_s = {pdiv_q[pll_q], 1'b0};
    if (pd_s == 6'd0) pd_s = 6'd2;
  end

  cgrb_pkg::div_req_t dreq;
  logic        ddone, mstart, mdone;
  logic [63:0] dquot;
  logic [47:0] mprod;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = {32'd0, fin_s};
    dreq.divisor  = n_s;
    mstart        = 1'b0;
    if (state_q == StPll && fin_s != 32'd0) dreq.start = 1'b1;
    if (state_q == StDiv1 && ddone) mstart = 1'b1;
    if (state_q == StMul && mdone) begin
      dreq.start    = 1'b1;
      dreq.dividend = {16'd0, mprod};
      dreq.divisor  = {26'd0, pd_q};
    end
  end

  cgrb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quot_o (dquot)
  );

  cgrb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart),
    .a_i     (dquot[31:0]),
    .b_i     (mdiv_q[pll_q]),
    .done_o  (mdone),
    .prod_o  (mprod)
  );

  // Read data with the fixed words substituted and the ready bit applied.
  function automatic logic [31:0] ready_fix(input logic [11:0] a, input logic [31:0] v,
                                            input logic [31:0] rc);
    logic [31:0] r;
    r = v;
    if (a == cgrb_pkg::WVersion) r = cgrb_pkg::VersionVal;
    else if (a == cgrb_pkg::WParam) r = 32'd0;
    else if (a == cgrb_pkg::WStatus) r = rc;
    else if (a == cgrb_pkg::WSosc || a == cgrb_pkg::WFirc) begin
      if (v[0]) r = v | cgrb_pkg::ReadyBit;
    end else if (a == cgrb_pkg::WRosc) begin
      if (v[16]) r = v | cgrb_pkg::ReadyBit;
    end else if (a == cgrb_pkg::WPllA || a == cgrb_pkg::WPllS) begin
      if (v[1:0] != 2'b00) r = v | cgrb_pkg::ReadyBit;
    end else if (a == cgrb_pkg::WSirc) r = v | cgrb_pkg::ReadyBit;
    return r;
  endfunction

  // Word read by the request, held until the response is built.
  logic [31:0] rdw_q;

  // Control sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      slot_q  <= 4'd0;
      fvalid_q <= 1'b0;
      fetch_q <= 4'd0;
      pll_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(cgrb_pkg::RegWords - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (s_axis_tvalid) state_q <= StAccess;
        end
        StAccess: begin
          state_q <= StRdWait;
        end
        StRdWait: begin
          rdw_q    <= rdata_q;
          slot_q   <= 4'd0;
          fvalid_q <= 1'b0;
          state_q  <= StFetch;
        end
        StFetch: begin
          fetch_q  <= slot_q;
          fvalid_q <= 1'b1;
          if (fvalid_q) begin
            case (fetch_q)
              4'd0:  runctl_q <= rdata_q;
              4'd1:  sosc_q <= rdata_q;
              4'd2:  sirc_q <= rdata_q;
              4'd3:  firc_q <= rdata_q;
              4'd4:  fcfg_q <= rdata_q;
              4'd5:  rosc_q <= rdata_q;
              4'd6:  csr_q[0] <= rdata_q;
              4'd7:  ctl_q[0] <= rdata_q;
              4'd8:  ndiv_q[0] <= rdata_q[7:0];
              4'd9:  mdiv_q[0] <= rdata_q[15:0];
              4'd10: pdiv_q[0] <= rdata_q[4:0];
              4'd11: csr_q[1] <= rdata_q;
              4'd12: ctl_q[1] <= rdata_q;
              4'd13: ndiv_q[1] <= rdata_q[7:0];
              4'd14: mdiv_q[1] <= rdata_q[15:0];
              default: pdiv_q[1] <= rdata_q[4:0];
            endcase
            if (fetch_q == 4'd15) begin
              pll_q   <= 1'b0;
              state_q <= StPll;
            end
          end
          if (slot_q != 4'd15) slot_q <= slot_q + 4'd1;
        end
        StPll: begin
          pd_q  <= pd_s;
          if (fin_s == 32'd0) begin
            hz_q[pll_q] <= 32'd0;
            if (pll_q) state_q <= StOut;
            pll_q <= 1'b1;
          end else begin
            state_q <= StDiv1;
          end
        end
        StDiv1: begin
          if (ddone) state_q <= StMul;
        end
        StMul: begin
          if (mdone) state_q <= StDiv2;
        end
        StDiv2: begin
          if (ddone) begin
            hz_q[pll_q] <= dquot[31:0];
            pll_q <= 1'b1;
            state_q <= pll_q ? StOut : StPll;
          end
        end
        StOut: begin
          rd_q <= (!kind_q && in_win) ? ready_fix(idx_q, rdw_q, runctl_q) : 32'd0;
          if (m_axis_tvalid && m_axis_tready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      idx_q  <= s_axis_tdata[43:32];
      wd_q   <= s_axis_tdata[31:0];
    end
  end

  // Output valid rises the cycle after the output state is entered, once the read word has settled.
  logic ovalid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
    else if (state_q == StOut) ovalid_q <= 1'b1;
  end

  logic [23:0] f12;
  logic [27:0] fhf;
  logic [31:0] fmain;
  always_comb begin
    f12 = sirc_q[5] ? 24'(cgrb_pkg::HzFro12) : 24'd0;
    fhf = firc_q[0] ? (fcfg_q[0] ? 28'(cgrb_pkg::HzFro144) : 28'(cgrb_pkg::HzFro48)) : 28'd0;
    case (runctl_q[27:24])
      4'd1: fmain = sosc_q[0] ? cgrb_pkg::HzSosc : 32'd0;
      4'd2: fmain = {8'd0, f12};
      4'd3: fmain = {4'd0, fhf};
      4'd4: fmain = rosc_q[16] ? cgrb_pkg::HzRosc : 32'd0;
      4'd5: fmain = hz_q[0];
      4'd6: fmain = hz_q[1];
      default: fmain = 32'd0;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, fmain, hz_q[1], hz_q[0], fhf, f12, rd_q};

endmodule

@@ hw/rtl/cgrb_div.sv @@
// ----------------------------------------------------------------------------
// Clock generator serial divider
// Restoring radix-2 divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module cgrb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cgrb_pkg::div_req_t req_i,
  output logic               done_o,
  output logic [63:0]        quot_o
);

  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  // One shift and trial subtract per cycle.
  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[31:0], quot_q[63]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = 33'd0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/cgrb_mul.sv @@
// ----------------------------------------------------------------------------
// Clock generator serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, 32 by 16 bits.
// ----------------------------------------------------------------------------
module cgrb_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [15:0] b_i,
  output logic        done_o,
  output logic [47:0] prod_o
);

  logic [47:0] acc_q, acc_d;
  logic [47:0] a_q, a_d;
  logic [15:0] b_q, b_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  // Add the shifted multiplicand when the low multiplier bit is set.
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = 48'd0;
      a_d    = {16'd0, a_i};
      b_d    = b_i;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = {a_q[46:0], 1'b0};
      b_d   = {1'b0, b_q[15:1]};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
